@@ rtl/dnle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the domain name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int MAX_LABEL = 62;
    localparam int LEN_W     = $clog2(MAX_LABEL + 1);
    localparam int CHAR_W    = 8;
    localparam int TOTAL_W   = 11;
    localparam int CAP_W     = 11;

    localparam logic [CHAR_W-1:0]  DOT_CHAR  = 8'h2E;
    localparam logic [CHAR_W-1:0]  NUL_CHAR  = 8'h00;
    localparam logic [CAP_W-1:0]   CAP_RESET = 11'd256;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/dnle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_name_if / dnle_wire_if
// Valid/ready channels for name characters and wire-format bytes.
// ----------------------------------------------------------------------------
interface dnle_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       end_of_name;

    modport source (output valid, output name_char, output end_of_name, input ready);
    modport sink   (input valid, input name_char, input end_of_name, output ready);
endinterface

interface dnle_wire_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       last;
    logic       too_big;
    logic       label_too_long;

    modport source (output valid, output wire_byte, output last, output too_big,
                    output label_too_long, input ready);
    modport sink   (input valid, input wire_byte, input last, input too_big,
                    input label_too_long, output ready);
endinterface

@@ rtl/dnle_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_cell
// One character slot of the label buffer; loads from the input or takes
// its upper neighbor's character when the label is drained.
// ----------------------------------------------------------------------------
module dnle_cell (
    input  logic                 clk,
    input  dnle_pkg::cell_ctrl_t ctrl,
    input  dnle_pkg::char_t      char_in,
    input  dnle_pkg::char_t      neighbor_in,
    output dnle_pkg::char_t      char_out
);
    import dnle_pkg::*;

    char_t char_reg;
    char_t char_next;

    always_comb
    begin
        char_next = char_reg;
        if (ctrl.load)
        begin
            char_next = char_in;
        end
        else if (ctrl.shift)
        begin
            char_next = neighbor_in;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_out = char_reg;

endmodule

@@ rtl/dns_name_label_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Dotted domain name to DNS wire-format label encoder.
// ----------------------------------------------------------------------------
// Usage:
//   name_ch carries one character item per handshake; an item with
//   end_of_name set closes the name. wire_ch returns the encoded bytes:
//   a length byte and the characters for each label, then a zero byte with
//   last set, carrying too_big and label_too_long for the whole name.
//   cfg_we/cfg_wdata set the wire capacity (reset value 256) while idle.
// Timing:
//   Plain characters do not drop name_ch.ready, so they stream at one per
//   cycle. A dot holds name_ch.ready low while the length byte is sent and
//   the characters leave through a row of 62 cells that shifts one character
//   per cycle toward the output while wire_ch is not stalled. The end item
//   does the same for any pending label, then sends the zero byte. After the
//   dot or end item is taken, S_LEN (or S_TERM) loads the first output byte.
//   A stall on wire_ch holds the drain; nothing is dropped.
// Reset:
//   rst_n clears the label count, byte count, flags and the output register.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    dnle_name_if.sink                 name_ch,
    dnle_wire_if.source               wire_ch,
    input  logic                      cfg_we,
    input  logic [dnle_pkg::CAP_W-1:0] cfg_wdata
);
    import dnle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_CHARS,
        S_TERM
    } state_t;

    state_t              state_reg, state_next;
    len_t                len_reg, len_next;
    len_t                rem_reg, rem_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                overlong_reg, overlong_next;
    logic                end_pend_reg, end_pend_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;

    logic                out_valid_reg, out_valid_next;
    char_t               byte_reg, byte_next;
    logic                last_reg, last_next;
    logic                big_reg, big_next;
    logic                long_reg, long_next;

    logic                accept;
    logic                slot_free;
    logic                load_en;
    logic                shift_en;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  sat_sum;
    logic [LEN_W:0]      add_n;

    char_t               cell_q [MAX_LABEL];

    assign accept    = name_ch.valid && name_ch.ready;
    assign slot_free = !out_valid_reg || wire_ch.ready;
    assign load_en   = accept && !name_ch.end_of_name && (name_ch.name_char != DOT_CHAR)
                       && (len_reg < len_t'(MAX_LABEL));
    assign shift_en  = (state_reg == S_CHARS) && slot_free;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LABEL; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            char_t      nbr;
            assign ctrl.load  = load_en && (len_reg == len_t'(gi));
            assign ctrl.shift = shift_en;
            if (gi == MAX_LABEL - 1)
            begin : g_end
                assign nbr = NUL_CHAR;
            end
            else
            begin : g_mid
                assign nbr = cell_q[gi+1];
            end
            dnle_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .char_in     (name_ch.name_char),
                .neighbor_in (nbr),
                .char_out    (cell_q[gi])
            );
        end
    endgenerate

    // byte count, saturating
    always_comb
    begin
        add_n = (state_reg == S_LEN) ? ({1'b0, len_reg} + 1'b1) : (LEN_W+1)'(1);
        sum   = {1'b0, total_reg} + (TOTAL_W+1)'(add_n);
        sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        total_next     = total_reg;
        overlong_next  = overlong_reg;
        end_pend_next  = end_pend_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        out_valid_next = out_valid_reg && !wire_ch.ready;
        byte_next      = byte_reg;
        last_next      = last_reg;
        big_next       = big_reg;
        long_next      = long_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (name_ch.end_of_name)
                    begin
                        end_pend_next = 1'b1;
                        state_next    = (len_reg != '0) ? S_LEN : S_TERM;
                    end
                    else if (name_ch.name_char == DOT_CHAR)
                    begin
                        end_pend_next = 1'b0;
                        state_next    = S_LEN;
                    end
                    else if (load_en)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        overlong_next = 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = char_t'(len_reg);
                    last_next      = 1'b0;
                    big_next       = 1'b0;
                    long_next      = 1'b0;
                    total_next     = sat_sum;
                    rem_next       = len_reg;
                    len_next       = '0;
                    if (len_reg != '0)
                    begin
                        state_next = S_CHARS;
                    end
                    else
                    begin
                        state_next = end_pend_reg ? S_TERM : S_IDLE;
                    end
                end
            end
            S_CHARS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = cell_q[0];
                    last_next      = 1'b0;
                    big_next       = 1'b0;
                    long_next      = 1'b0;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == len_t'(1))
                    begin
                        state_next = end_pend_reg ? S_TERM : S_IDLE;
                    end
                end
            end
            S_TERM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = NUL_CHAR;
                    last_next      = 1'b1;
                    big_next       = sat_sum > cap_reg;
                    long_next      = overlong_reg;
                    total_next     = '0;
                    overlong_next  = 1'b0;
                    len_next       = '0;
                    end_pend_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rem_reg       <= '0;
            total_reg     <= '0;
            overlong_reg  <= 1'b0;
            end_pend_reg  <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            big_reg       <= 1'b0;
            long_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            total_reg     <= total_next;
            overlong_reg  <= overlong_next;
            end_pend_reg  <= end_pend_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            big_reg       <= big_next;
            long_reg      <= long_next;
        end
    end

    assign name_ch.ready          = (state_reg == S_IDLE);
    assign wire_ch.valid          = out_valid_reg;
    assign wire_ch.wire_byte      = byte_reg;
    assign wire_ch.last           = last_reg;
    assign wire_ch.too_big        = big_reg;
    assign wire_ch.label_too_long = long_reg;

    // flags only ride on the terminator
    a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (!big_reg && !long_reg))
        else $error("error flag on non-terminator item");

    // a dot always starts a flush
    a_dot_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !name_ch.end_of_name && name_ch.name_char == DOT_CHAR)
        |=> !name_ch.ready)
        else $error("dot accepted without flush");

    // label count never passes the cell row
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= len_t'(MAX_LABEL)) && (rem_reg <= len_t'(MAX_LABEL)))
        else $error("label count out of range");

    // the drain never starts with nothing left to send
    a_drain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHARS) |-> (rem_reg != '0))
        else $error("drain with empty label");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dns_name_label_encoder_core. Dotted names are fed
// in as character items, some well-formed, some noisy. An encoder model in
// the bench computes the wire bytes and the end-of-name flags as each item
// is accepted. Every byte that leaves the block is checked in order against
// that model. The wire capacity is changed between phases, and both sides
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dnle_pkg::*;

    localparam int HOLD_LONG   = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 100;

    typedef struct packed {
        char_t ch;
        logic  eon;
    } name_item_t;

    typedef struct packed {
        char_t wbyte;
        logic  last;
        logic  big;
        logic  cut;
    } wire_item_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             nm_valid  = 1'b0;
    char_t            nm_char   = '0;
    logic             nm_eon    = 1'b0;
    logic             wr_ready  = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    // encoder model state
    char_t            lbl_buf [MAX_LABEL];
    int               lbl_len    = 0;
    int               wire_count = 0;
    logic             cut_seen   = 1'b0;
    logic [CAP_W-1:0] cap_model  = CAP_RESET;

    name_item_t pending_chars [$];
    wire_item_t wire_due_q [$];

    int n_errors     = 0;
    int src_gap      = 0;
    int snk_hold     = 0;
    int quiet_cycles = 0;
    bit src_idle     = 1'b0;
    bit snk_idle     = 1'b0;
    bit long_done    = 1'b0;

    dnle_name_if name_if ();
    dnle_wire_if wire_if ();

    assign name_if.valid       = nm_valid;
    assign name_if.name_char   = nm_char;
    assign name_if.end_of_name = nm_eon;
    assign wire_if.ready       = wr_ready;

    dns_name_label_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .name_ch   (name_if),
        .wire_ch   (wire_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void count_wire(input int n);
        wire_count += n;
        if (wire_count > int'(TOTAL_MAX))
            wire_count = int'(TOTAL_MAX);
    endfunction

    function void flush_label();
        wire_due_q.push_back('{char_t'(lbl_len), 1'b0, 1'b0, 1'b0});
        for (int i = 0; i < lbl_len; i++)
            wire_due_q.push_back('{lbl_buf[i], 1'b0, 1'b0, 1'b0});
        count_wire(lbl_len + 1);
        lbl_len = 0;
    endfunction

    function void encode_item(input char_t ch, input logic eon);
        if (!eon)
        begin
            if (ch == DOT_CHAR)
                flush_label();
            else if (lbl_len < MAX_LABEL)
            begin
                lbl_buf[lbl_len] = ch;
                lbl_len++;
            end
            else
                cut_seen = 1'b1;
        end
        else
        begin
            if (lbl_len > 0)
                flush_label();
            count_wire(1);
            wire_due_q.push_back('{NUL_CHAR, 1'b1, wire_count > int'(cap_model), cut_seen});
            lbl_len    = 0;
            wire_count = 0;
            cut_seen   = 1'b0;
        end
    endfunction

    function void check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            n_errors++;
        end
    endfunction

    // sender
    always @(posedge clk)
    begin : name_driver
        name_item_t nxt;
        if (!rst_n)
        begin
            nm_valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (nm_valid && name_if.ready)
                encode_item(nm_char, nm_eon);
            if (!nm_valid || name_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    nm_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    nxt = pending_chars.pop_front();
                    nm_valid <= 1'b1;
                    nm_char  <= nxt.ch;
                    nm_eon   <= nxt.eon;
                    if (src_idle && $urandom_range(0, 99) < 10)
                        src_gap = $urandom_range(1, 19);
                end
                else
                    nm_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : wire_monitor
        wire_item_t got;
        wire_item_t want;
        if (!rst_n)
        begin
            wr_ready <= 1'b0;
            snk_hold = 0;
        end
        else
        begin
            if (wire_if.valid && wr_ready)
            begin
                got = '{wire_if.wire_byte, wire_if.last, wire_if.too_big,
                        wire_if.label_too_long};
                if (wire_due_q.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %0h last %b",
                             $time, got.wbyte, got.last);
                    n_errors++;
                end
                else
                begin
                    want = wire_due_q.pop_front();
                    check_field("wire_byte", want.wbyte, got.wbyte);
                    check_field("last", want.last, got.last);
                    check_field("too_big", want.big, got.big);
                    check_field("label_too_long", want.cut, got.cut);
                end
            end
            if (snk_hold > 0)
            begin
                snk_hold--;
                wr_ready <= 1'b0;
            end
            else if (!long_done && nm_valid && pending_chars.size() > 60)
            begin
                // long back-pressure so the label row fills and input stalls
                long_done = 1'b1;
                snk_hold  = HOLD_LONG - 1;
                wr_ready <= 1'b0;
            end
            else if (snk_idle && $urandom_range(0, 99) < 8)
            begin
                snk_hold = $urandom_range(0, 18);
                wr_ready <= 1'b0;
            end
            else
                wr_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((nm_valid && name_if.ready) || (wire_if.valid && wr_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function void queue_char(input char_t ch, input logic eon);
        pending_chars.push_back('{ch, eon});
    endfunction

    function automatic char_t label_char();
        char_t c;
        do
            c = char_t'($urandom_range(0, 255));
        while (c == DOT_CHAR);
        return c;
    endfunction

    function automatic int queue_random_name();
        int n_lbl;
        int len;
        int cnt;
        cnt   = 0;
        n_lbl = $urandom_range(0, 5);
        for (int l = 0; l < n_lbl; l++)
        begin
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 8);
            else
                len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                queue_char(label_char(), 1'b0);
            cnt += len;
            if (l < n_lbl - 1 || $urandom_range(0, 3) == 0)
            begin
                queue_char(DOT_CHAR, 1'b0);
                cnt++;
            end
        end
        queue_char(char_t'($urandom_range(0, 255)), 1'b1);
        return cnt + 1;
    endfunction

    function automatic int queue_noise_name();
        int len;
        len = $urandom_range(0, 20);
        for (int i = 0; i < len; i++)
            queue_char(($urandom_range(0, 3) == 0) ? DOT_CHAR
                                                   : char_t'($urandom_range(0, 255)), 1'b0);
        queue_char(char_t'($urandom_range(0, 255)), 1'b1);
        return len + 1;
    endfunction

    function automatic void queue_random_names(input int n_items);
        int cnt;
        cnt = 0;
        while (cnt < n_items)
            cnt += ($urandom_range(0, 9) == 0) ? queue_noise_name() : queue_random_name();
    endfunction

    // k labels of MAX_LABEL chars: wire size k*(MAX_LABEL+1)+1
    function automatic void queue_long_name(input int k);
        for (int l = 0; l < k; l++)
        begin
            for (int i = 0; i < MAX_LABEL; i++)
                queue_char(label_char(), 1'b0);
            queue_char(DOT_CHAR, 1'b0);
        end
        queue_char(NUL_CHAR, 1'b1);
    endfunction

    task automatic wait_idle();
        while (pending_chars.size() != 0 || nm_valid || wire_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_model = cap;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        @(negedge clk);

        // empty name
        queue_char(NUL_CHAR, 1'b1);
        // lone dot
        queue_char(DOT_CHAR, 1'b0);
        queue_char(NUL_CHAR, 1'b1);
        // consecutive dots, label closed by end
        queue_char(DOT_CHAR, 1'b0);
        queue_char(DOT_CHAR, 1'b0);
        queue_char("a", 1'b0);
        queue_char(NUL_CHAR, 1'b1);
        // trailing dot
        queue_char("a", 1'b0);
        queue_char(DOT_CHAR, 1'b0);
        queue_char("b", 1'b0);
        queue_char(DOT_CHAR, 1'b0);
        queue_char(8'hFF, 1'b1);
        // zero and extreme chars; char on end item is ignored
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h7F, 1'b0);
        queue_char(DOT_CHAR, 1'b1);
        wait_idle();

        write_capacity(11'd1);
        queue_random_names(50);
        wait_idle();

        write_capacity(11'd0);
        src_idle = 1'b0;
        queue_random_names(40);
        wait_idle();

        // two full labels: wire size 127, above this capacity
        write_capacity(11'd100);
        src_idle = 1'b1;
        snk_idle = 1'b0;
        queue_long_name(2);
        queue_random_names(40);
        wait_idle();

        snk_idle = 1'b1;
        repeat (2)
        begin
            write_capacity(CAP_W'($urandom_range(2, 80)));
            queue_random_names(40);
            wait_idle();
        end

        write_capacity(CAP_RESET);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        queue_random_names(80);
        wait_idle();

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
